// ===== rtl/hcmb_pkg.sv =====
package hcmb_pkg;

    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 16;
    localparam int BYTE_W  = 8;
    localparam int CMD_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    localparam int MEM_DEPTH = 65536;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_KEYS  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_OVERLAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_PROTECT  = 2'd1;

    localparam logic [ADDR_W-1:0] ADDR_VRAM      = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_ECHO      = 16'hE000;
    localparam logic [ADDR_W-1:0] ADDR_SPRITE    = 16'hFE00;
    localparam logic [ADDR_W-1:0] ADDR_UNUSABLE  = 16'hFEA0;
    localparam logic [ADDR_W-1:0] ADDR_IO        = 16'hFF00;
    localparam logic [ADDR_W-1:0] ADDR_JOYPAD    = 16'hFF00;
    localparam logic [ADDR_W-1:0] ADDR_TIMER_CTL = 16'hFF07;
    localparam logic [ADDR_W-1:0] ADDR_DMA       = 16'hFF46;
    localparam logic [ADDR_W-1:0] ADDR_LAST      = 16'hFFFF;
    localparam logic [ADDR_W-1:0] BANK_MASK      = 16'h1FFF;
    localparam logic [ADDR_W-1:0] WRAM_BASE      = 16'hC000;

    localparam logic [BYTE_W-1:0] JOYPAD_RESET = 8'hCF;
    localparam logic [1:0] JOY_SEL_DIR = 2'b10;
    localparam logic [1:0] JOY_SEL_BTN = 2'b01;
    localparam logic [1:0] TIMER_RATE_MASK = 2'b11;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DONE
    } state_t;

    localparam logic [BYTE_W-1:0] BOOT_IMAGE [256] = '{
        8'h31, 8'hFE, 8'hFF, 8'hAF, 8'h21, 8'hFF, 8'h9F, 8'h32,
        8'hCB, 8'h7C, 8'h20, 8'hFB, 8'h21, 8'h26, 8'hFF, 8'h0E,
        8'h11, 8'h3E, 8'h80, 8'h32, 8'hE2, 8'h0C, 8'h3E, 8'hF3,
        8'hE2, 8'h32, 8'h3E, 8'h77, 8'h77, 8'h3E, 8'hFC, 8'hE0,
        8'h47, 8'h11, 8'h04, 8'h01, 8'h21, 8'h10, 8'h80, 8'h1A,
        8'hCD, 8'h95, 8'h00, 8'hCD, 8'h96, 8'h00, 8'h13, 8'h7B,
        8'hFE, 8'h34, 8'h20, 8'hF3, 8'h11, 8'hD8, 8'h00, 8'h06,
        8'h08, 8'h1A, 8'h13, 8'h22, 8'h23, 8'h05, 8'h20, 8'hF9,
        8'h3E, 8'h19, 8'hEA, 8'h10, 8'h99, 8'h21, 8'h2F, 8'h99,
        8'h0E, 8'h0C, 8'h3D, 8'h28, 8'h08, 8'h32, 8'h0D, 8'h20,
        8'hF9, 8'h2E, 8'h0F, 8'h18, 8'hF3, 8'h67, 8'h3E, 8'h64,
        8'h57, 8'hE0, 8'h42, 8'h3E, 8'h91, 8'hE0, 8'h40, 8'h04,
        8'h1E, 8'h02, 8'h0E, 8'h0C, 8'hF0, 8'h44, 8'hFE, 8'h90,
        8'h20, 8'hFA, 8'h0D, 8'h20, 8'hF7, 8'h1D, 8'h20, 8'hF2,
        8'h0E, 8'h13, 8'h24, 8'h7C, 8'h1E, 8'h83, 8'hFE, 8'h62,
        8'h28, 8'h06, 8'h1E, 8'hC1, 8'hFE, 8'h64, 8'h20, 8'h06,
        8'h7B, 8'hE2, 8'h0C, 8'h3E, 8'h87, 8'hE2, 8'hF0, 8'h42,
        8'h90, 8'hE0, 8'h42, 8'h15, 8'h20, 8'hD2, 8'h05, 8'h20,
        8'h4F, 8'h16, 8'h20, 8'h18, 8'hCB, 8'h4F, 8'h06, 8'h04,
        8'hC5, 8'hCB, 8'h11, 8'h17, 8'hC1, 8'hCB, 8'h11, 8'h17,
        8'h05, 8'h20, 8'hF5, 8'h22, 8'h23, 8'h22, 8'h23, 8'hC9,
        8'hCE, 8'hED, 8'h66, 8'h66, 8'hCC, 8'h0D, 8'h00, 8'h0B,
        8'h03, 8'h73, 8'h00, 8'h83, 8'h00, 8'h0C, 8'h00, 8'h0D,
        8'h00, 8'h08, 8'h11, 8'h1F, 8'h88, 8'h89, 8'h00, 8'h0E,
        8'hDC, 8'hCC, 8'h6E, 8'hE6, 8'hDD, 8'hDD, 8'hD9, 8'h99,
        8'hBB, 8'hBB, 8'h67, 8'h63, 8'h6E, 8'h0E, 8'hEC, 8'hCC,
        8'hDD, 8'hDC, 8'h99, 8'h9F, 8'hBB, 8'hB9, 8'h33, 8'h3E,
        8'h3C, 8'h42, 8'hB9, 8'hA5, 8'hB9, 8'hA5, 8'h42, 8'h3C,
        8'h21, 8'h04, 8'h01, 8'h11, 8'hA8, 8'h00, 8'h1A, 8'h13,
        8'hBE, 8'h20, 8'hFE, 8'h23, 8'h7D, 8'hFE, 8'h34, 8'h20,
        8'hF5, 8'h06, 8'h19, 8'h78, 8'h86, 8'h23, 8'h05, 8'h20,
        8'hFB, 8'h86, 8'h20, 8'hFE, 8'h3E, 8'h01, 8'hE0, 8'h50
    };

endpackage

// ===== rtl/hcmb_req_if.sv =====
interface hcmb_req_if;
    logic                         valid;
    logic                         ready;
    logic [hcmb_pkg::CMD_W-1:0]   command;
    logic [hcmb_pkg::ADDR_W-1:0]  address;
    logic [hcmb_pkg::DATA_W-1:0]  write_data;
    logic                         word_access;
    logic [hcmb_pkg::BYTE_W-1:0]  key_state;

    modport source (output valid, command, address, write_data, word_access, key_state,
                    input ready);
    modport sink (input valid, command, address, write_data, word_access, key_state,
                  output ready);
endinterface

// ===== rtl/hcmb_rsp_if.sv =====
interface hcmb_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [hcmb_pkg::DATA_W-1:0]  read_data;
    logic                         dma_start;
    logic [hcmb_pkg::BYTE_W-1:0]  dma_source_page;
    logic                         timer_restart;

    modport source (output valid, read_data, dma_start, dma_source_page, timer_restart,
                    input ready);
    modport sink (input valid, read_data, dma_start, dma_source_page, timer_restart,
                  output ready);
endinterface

// ===== rtl/handheld_console_memory_bus.sv =====
// memory map bus for an 8-bit handheld console
// req: command word (read, write, key update) with address, write data,
//   word flag and key state; accepted when valid and ready are both high
// rsp: one word per command with read data, dma pulse and page, timer pulse
// cfg: cfg_we/cfg_index/cfg_wdata write the boot overlay enable (index 0)
//   and the rom write protect (index 1); other indexes are ignored
// all map storage sits in one 64k x 8 single-port ram with a registered read;
// each byte takes a read state and an update state on that port
// one command in flight; next command accepted once the current result is
// in the rsp register
// reset: the ram is cleared (joypad port set to 0xcf) while req.ready
// stays low; config writes are taken during that pass
// rsp stall: the result holds in the rsp register, a following command can
// be accepted and waits in its last state until the register frees
module handheld_console_memory_bus (
    input  logic                              clk,
    input  logic                              rst_n,
    hcmb_req_if.sink                          req,
    hcmb_rsp_if.source                        rsp,
    input  logic                              cfg_we,
    input  logic [hcmb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hcmb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [hcmb_pkg::BYTE_W-1:0] mem [hcmb_pkg::MEM_DEPTH];

    hcmb_pkg::state_t state_reg, state_next;

    logic                         boot_en_reg;
    logic                         protect_reg;
    logic [hcmb_pkg::BYTE_W-1:0]  keys_reg;
    logic [hcmb_pkg::ADDR_W-1:0]  clr_addr_reg;

    logic [hcmb_pkg::CMD_W-1:0]   cmd_reg;
    logic [hcmb_pkg::ADDR_W-1:0]  addr_reg;
    logic [hcmb_pkg::DATA_W-1:0]  wdata_reg;
    logic                         word_reg;
    logic                         byte_hi_reg;

    logic [hcmb_pkg::DATA_W-1:0]  rdata_acc_reg;
    logic                         dma_acc_reg;
    logic [hcmb_pkg::BYTE_W-1:0]  page_acc_reg;
    logic                         timer_acc_reg;

    logic                         rsp_valid_reg;
    logic [hcmb_pkg::DATA_W-1:0]  rsp_data_reg;
    logic                         rsp_dma_reg;
    logic [hcmb_pkg::BYTE_W-1:0]  rsp_page_reg;
    logic                         rsp_timer_reg;

    logic [hcmb_pkg::BYTE_W-1:0]  mem_rdata_reg;
    logic [hcmb_pkg::ADDR_W-1:0]  mem_addr;
    logic                         mem_we;
    logic [hcmb_pkg::BYTE_W-1:0]  mem_wdata;

    logic                         accept;
    logic                         last_byte;
    logic                         out_load;
    logic [hcmb_pkg::ADDR_W-1:0]  cur_addr;
    logic [hcmb_pkg::ADDR_W-1:0]  phys_addr;
    logic [hcmb_pkg::BYTE_W-1:0]  cur_byte;
    logic                         is_rom;
    logic                         is_unusable;
    logic                         is_boot;
    logic                         wr_ok;
    logic [3:0]                   joy_keys;
    logic [hcmb_pkg::BYTE_W-1:0]  rd_byte;
    logic                         dma_hit;
    logic                         timer_hit;

    assign accept    = req.valid && req.ready;
    assign last_byte = !word_reg || byte_hi_reg;
    assign out_load  = !rsp_valid_reg || rsp.ready;
    assign cur_addr  = addr_reg + {{(hcmb_pkg::ADDR_W-1){1'b0}}, byte_hi_reg};
    assign cur_byte  = byte_hi_reg ? wdata_reg[15:8] : wdata_reg[7:0];

    assign is_rom      = cur_addr < hcmb_pkg::ADDR_VRAM;
    assign is_unusable = (cur_addr >= hcmb_pkg::ADDR_UNUSABLE) && (cur_addr < hcmb_pkg::ADDR_IO);
    assign is_boot     = boot_en_reg && (cur_addr[15:8] == 8'h00);
    assign wr_ok       = (cmd_reg == hcmb_pkg::CMD_WRITE) && !is_unusable
                         && !(is_rom && protect_reg);

    // echo area folds onto work ram
    always_comb
    begin
        if ((cur_addr >= hcmb_pkg::ADDR_ECHO) && (cur_addr < hcmb_pkg::ADDR_SPRITE))
        begin
            phys_addr = hcmb_pkg::WRAM_BASE | (cur_addr & hcmb_pkg::BANK_MASK);
        end
        else
        begin
            phys_addr = cur_addr;
        end
    end

    always_comb
    begin
        case (mem_rdata_reg[5:4])
            hcmb_pkg::JOY_SEL_DIR: joy_keys = keys_reg[3:0];
            hcmb_pkg::JOY_SEL_BTN: joy_keys = keys_reg[7:4];
            default:               joy_keys = 4'h0;
        endcase
    end

    always_comb
    begin
        if (is_unusable)
        begin
            rd_byte = '0;
        end
        else if (is_boot)
        begin
            rd_byte = hcmb_pkg::BOOT_IMAGE[cur_addr[7:0]];
        end
        else if (cur_addr == hcmb_pkg::ADDR_JOYPAD)
        begin
            rd_byte = {mem_rdata_reg[7:4], joy_keys};
        end
        else
        begin
            rd_byte = mem_rdata_reg;
        end
    end

    assign dma_hit   = wr_ok && (cur_addr == hcmb_pkg::ADDR_DMA);
    assign timer_hit = wr_ok && (cur_addr == hcmb_pkg::ADDR_TIMER_CTL)
                       && (((mem_rdata_reg[1:0] ^ cur_byte[1:0])
                            & hcmb_pkg::TIMER_RATE_MASK) != 2'b00);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hcmb_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == hcmb_pkg::ADDR_LAST)
                begin
                    state_next = hcmb_pkg::ST_IDLE;
                end
            end
            hcmb_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if ((req.command == hcmb_pkg::CMD_READ)
                        || (req.command == hcmb_pkg::CMD_WRITE))
                    begin
                        state_next = hcmb_pkg::ST_READ;
                    end
                    else
                    begin
                        state_next = hcmb_pkg::ST_DONE;
                    end
                end
            end
            hcmb_pkg::ST_READ:
            begin
                state_next = hcmb_pkg::ST_UPDATE;
            end
            hcmb_pkg::ST_UPDATE:
            begin
                state_next = last_byte ? hcmb_pkg::ST_DONE : hcmb_pkg::ST_READ;
            end
            hcmb_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = hcmb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcmb_pkg::ST_IDLE;
            end
        endcase
    end

    // ram port and handshake
    always_comb
    begin
        mem_addr  = phys_addr;
        mem_we    = 1'b0;
        mem_wdata = cur_byte;
        req.ready = 1'b0;
        case (state_reg)
            hcmb_pkg::ST_CLEAR:
            begin
                mem_addr  = clr_addr_reg;
                mem_we    = 1'b1;
                mem_wdata = (clr_addr_reg == hcmb_pkg::ADDR_JOYPAD) ?
                            hcmb_pkg::JOYPAD_RESET : '0;
            end
            hcmb_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            hcmb_pkg::ST_UPDATE:
            begin
                mem_we = wr_ok;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcmb_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            boot_en_reg   <= 1'b0;
            protect_reg   <= 1'b0;
            keys_reg      <= 8'hFF;
            byte_hi_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == hcmb_pkg::ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 16'd1;
            end
            if (cfg_we && (cfg_index == hcmb_pkg::CFG_BOOT_OVERLAY))
            begin
                boot_en_reg <= cfg_wdata[0];
            end
            if (cfg_we && (cfg_index == hcmb_pkg::CFG_ROM_PROTECT))
            begin
                protect_reg <= cfg_wdata[0];
            end
            if (accept && (req.command == hcmb_pkg::CMD_KEYS))
            begin
                keys_reg <= req.key_state;
            end
            if (accept)
            begin
                byte_hi_reg <= 1'b0;
            end
            else if (state_reg == hcmb_pkg::ST_UPDATE)
            begin
                byte_hi_reg <= 1'b1;
            end
            if ((state_reg == hcmb_pkg::ST_DONE) && out_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg       <= req.command;
            addr_reg      <= req.address;
            wdata_reg     <= req.write_data;
            word_reg      <= req.word_access;
            rdata_acc_reg <= '0;
            dma_acc_reg   <= 1'b0;
            page_acc_reg  <= '0;
            timer_acc_reg <= 1'b0;
        end
        else if (state_reg == hcmb_pkg::ST_UPDATE)
        begin
            if (cmd_reg == hcmb_pkg::CMD_READ)
            begin
                if (byte_hi_reg)
                begin
                    rdata_acc_reg[15:8] <= rd_byte;
                end
                else
                begin
                    rdata_acc_reg[7:0] <= rd_byte;
                end
            end
            if (dma_hit)
            begin
                dma_acc_reg  <= 1'b1;
                page_acc_reg <= cur_byte;
            end
            if (timer_hit)
            begin
                timer_acc_reg <= 1'b1;
            end
        end
        if ((state_reg == hcmb_pkg::ST_DONE) && out_load)
        begin
            rsp_data_reg  <= rdata_acc_reg;
            rsp_dma_reg   <= dma_acc_reg;
            rsp_page_reg  <= page_acc_reg;
            rsp_timer_reg <= timer_acc_reg;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.read_data       = rsp_data_reg;
    assign rsp.dma_start       = rsp_dma_reg;
    assign rsp.dma_source_page = rsp_page_reg;
    assign rsp.timer_restart   = rsp_timer_reg;

`ifndef SYNTHESIS
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hcmb_pkg::ST_CLEAR) |-> !req.ready)
        else $error("command accepted during ram clear");

    a_word_second_byte: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == hcmb_pkg::ST_UPDATE) && !last_byte)
        |=> ((state_reg == hcmb_pkg::ST_READ) && byte_hi_reg))
        else $error("second byte of word access skipped");

    a_page_without_dma: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.dma_start) |-> (rsp.dma_source_page == 8'h00))
        else $error("dma page set without dma pulse");

    a_nonread_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == hcmb_pkg::ST_DONE) && out_load && (cmd_reg != hcmb_pkg::CMD_READ))
        |=> (rsp.read_data == 16'h0000))
        else $error("read data not zero for non-read command");

    a_no_write_outside_update: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && (state_reg != hcmb_pkg::ST_CLEAR)) |-> (state_reg == hcmb_pkg::ST_UPDATE))
        else $error("ram write outside update cycle");
`endif

endmodule

// ===== sim/handheld_console_memory_bus_tb.sv =====
module handheld_console_memory_bus_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hcmb_pkg::*;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_STALL = 400;
    localparam int PHASES = 5;
    localparam logic [PHASES-1:0] OVERLAY_PLAN = 5'b00110;
    localparam logic [PHASES-1:0] PROTECT_PLAN = 5'b01100;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
        logic              word_access;
        logic [BYTE_W-1:0] key_state;
    } bus_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              dma_start;
        logic [BYTE_W-1:0] dma_source_page;
        logic              timer_restart;
    } bus_rsp_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic              cmd_valid = 1'b0;
    bus_cmd_t          cmd_word = '0;
    logic              rsp_ready = 1'b0;
    logic              cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    hcmb_req_if req_bus ();
    hcmb_rsp_if rsp_bus ();

    assign req_bus.valid       = cmd_valid;
    assign req_bus.command     = cmd_word.command;
    assign req_bus.address     = cmd_word.address;
    assign req_bus.write_data  = cmd_word.write_data;
    assign req_bus.word_access = cmd_word.word_access;
    assign req_bus.key_state   = cmd_word.key_state;
    assign rsp_bus.ready       = rsp_ready;

    handheld_console_memory_bus dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    // memory map as the bus should see it
    logic [7:0] cart_bytes [32768];
    logic [7:0] vram_bytes [8192];
    logic [7:0] xram_bytes [8192];
    logic [7:0] wram_bytes [8192];
    logic [7:0] oam_bytes  [160];
    logic [7:0] io_bytes   [128];
    logic [7:0] hram_bytes [127];
    logic [7:0] ie_reg;
    logic [7:0] key_bits;
    logic       overlay_on;
    logic       rom_locked;
    logic       pulse_dma;
    logic [7:0] pulse_page;
    logic       pulse_timer;

    bus_cmd_t pending_cmds [$];
    bus_rsp_t expected_rsps [$];
    logic [15:0] written_addrs [$];

    int send_idle_pct = 11;
    int recv_idle_pct = 61;
    int mismatches = 0;
    int cycles = 0;
    logic want_stall = 1'b0;
    logic stall_taken = 1'b0;
    int stall_left = 0;

    function automatic logic [7:0] load_byte(input logic [15:0] a);
        logic [7:0] p;
        logic [3:0] nib;
        p = io_bytes[a[6:0]];
        nib = 4'h0;
        if (a < ADDR_VRAM)
            return (overlay_on && a < 16'h0100) ? BOOT_IMAGE[a[7:0]] : cart_bytes[a[14:0]];
        if (a < 16'hA000)
            return vram_bytes[a[12:0]];
        if (a < WRAM_BASE)
            return xram_bytes[a[12:0]];
        if (a < ADDR_SPRITE)
            return wram_bytes[a[12:0]];
        if (a < ADDR_UNUSABLE)
            return oam_bytes[a[7:0]];
        if (a < ADDR_IO)
            return 8'h00;
        if (a < 16'hFF80)
        begin
            if (a != ADDR_JOYPAD)
                return p;
            if (p[5:4] == JOY_SEL_DIR)
                nib = key_bits[3:0];
            else if (p[5:4] == JOY_SEL_BTN)
                nib = key_bits[7:4];
            return {p[7:4], nib};
        end
        if (a < ADDR_LAST)
            return hram_bytes[a[6:0]];
        return ie_reg;
    endfunction

    function automatic void store_byte(input logic [15:0] a, input logic [7:0] v);
        logic [7:0] old;
        if (a < ADDR_VRAM)
        begin
            if (!rom_locked)
                cart_bytes[a[14:0]] = v;
        end
        else if (a < 16'hA000)
            vram_bytes[a[12:0]] = v;
        else if (a < WRAM_BASE)
            xram_bytes[a[12:0]] = v;
        else if (a < ADDR_SPRITE)
            wram_bytes[a[12:0]] = v;
        else if (a < ADDR_UNUSABLE)
            oam_bytes[a[7:0]] = v;
        else if (a < ADDR_IO)
        begin
        end
        else if (a < 16'hFF80)
        begin
            old = io_bytes[a[6:0]];
            io_bytes[a[6:0]] = v;
            if (a == ADDR_TIMER_CTL && ((old[1:0] ^ v[1:0]) & TIMER_RATE_MASK) != 2'b00)
                pulse_timer = 1'b1;
            if (a == ADDR_DMA)
            begin
                pulse_dma = 1'b1;
                pulse_page = v;
            end
        end
        else if (a < ADDR_LAST)
            hram_bytes[a[6:0]] = v;
        else
            ie_reg = v;
    endfunction

    function automatic bus_rsp_t bus_response(input bus_cmd_t c);
        bus_rsp_t r;
        r = '0;
        pulse_dma = 1'b0;
        pulse_page = 8'h00;
        pulse_timer = 1'b0;
        case (c.command)
            CMD_READ:
            begin
                r.read_data[7:0] = load_byte(c.address);
                if (c.word_access)
                    r.read_data[15:8] = load_byte(c.address + 16'd1);
            end
            CMD_WRITE:
            begin
                store_byte(c.address, c.write_data[7:0]);
                if (c.word_access)
                    store_byte(c.address + 16'd1, c.write_data[15:8]);
            end
            CMD_KEYS: key_bits = c.key_state;
            default: ;
        endcase
        r.dma_start = pulse_dma;
        r.dma_source_page = pulse_page;
        r.timer_restart = pulse_timer;
        return r;
    endfunction

    task automatic clear_map();
        foreach (cart_bytes[i]) cart_bytes[i] = 8'h00;
        foreach (vram_bytes[i]) vram_bytes[i] = 8'h00;
        foreach (xram_bytes[i]) xram_bytes[i] = 8'h00;
        foreach (wram_bytes[i]) wram_bytes[i] = 8'h00;
        foreach (oam_bytes[i]) oam_bytes[i] = 8'h00;
        foreach (io_bytes[i]) io_bytes[i] = 8'h00;
        foreach (hram_bytes[i]) hram_bytes[i] = 8'h00;
        io_bytes[0] = JOYPAD_RESET;
        ie_reg = 8'h00;
        key_bits = 8'hFF;
        overlay_on = 1'b0;
        rom_locked = 1'b0;
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_valid <= 1'b0;
        else if (!cmd_valid || req_bus.ready)
        begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                cmd_word <= pending_cmds.pop_front();
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (want_stall && !stall_taken)
        begin
            stall_left <= LONG_STALL;
            stall_taken <= 1'b1;
        end
        else if (stall_left != 0)
            stall_left <= stall_left - 1;
    end

    always @(posedge clk)
        rsp_ready <= rst_n && stall_left == 0 && $urandom_range(99) >= recv_idle_pct;

    // monitor and checker
    always @(posedge clk)
    begin
        bus_cmd_t seen;
        bus_rsp_t got;
        bus_rsp_t want;
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                seen.command = req_bus.command;
                seen.address = req_bus.address;
                seen.write_data = req_bus.write_data;
                seen.word_access = req_bus.word_access;
                seen.key_state = req_bus.key_state;
                expected_rsps.push_back(bus_response(seen));
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.read_data = rsp_bus.read_data;
                got.dma_start = rsp_bus.dma_start;
                got.dma_source_page = rsp_bus.dma_source_page;
                got.timer_restart = rsp_bus.timer_restart;
                if (expected_rsps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: rd=%h dma=%b page=%h tmr=%b", got.read_data,
                                 got.dma_start, got.dma_source_page, got.timer_restart);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (want.read_data !== got.read_data || want.dma_start !== got.dma_start ||
                        want.dma_source_page !== got.dma_source_page ||
                        want.timer_restart !== got.timer_restart)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected rd=%h dma=%b page=%h tmr=%b, got rd=%h dma=%b page=%h tmr=%b",
                                     want.read_data, want.dma_start, want.dma_source_page,
                                     want.timer_restart, got.read_data, got.dma_start,
                                     got.dma_source_page, got.timer_restart);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("handheld_console_memory_bus_tb failed");
            $finish;
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] op, input logic [15:0] a,
                             input logic [15:0] d, input logic w, input logic [7:0] k);
        bus_cmd_t c;
        c.command = op;
        c.address = a;
        c.write_data = d;
        c.word_access = w;
        c.key_state = k;
        pending_cmds.push_back(c);
    endtask

    task automatic wait_quiet();
        @(negedge clk);
        while (pending_cmds.size() != 0 || cmd_valid || expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == CFG_BOOT_OVERLAY)
            overlay_on = val;
        else if (idx == CFG_ROM_PROTECT)
            rom_locked = val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_address();
        logic [15:0] base;
        logic [15:0] span;
        logic [15:0] off;
        base = 16'h0000;
        span = 16'hFFFF;
        case ($urandom_range(11))
            0: begin base = 16'h0000; span = 16'h7FFF; end
            1: begin base = 16'h8000; span = 16'h1FFF; end
            2: begin base = 16'hA000; span = 16'h1FFF; end
            3: begin base = 16'hC000; span = 16'h1FFF; end
            4: begin base = 16'hE000; span = 16'h1DFF; end
            5: begin base = 16'hFE00; span = 16'h009F; end
            6: begin base = 16'hFEA0; span = 16'h005F; end
            7: begin base = 16'hFF00; span = 16'h007F; end
            8: begin base = 16'hFF80; span = 16'h007F; end
            9:
            begin
                span = 16'h0000;
                case ($urandom_range(12))
                    0: base = ADDR_JOYPAD;
                    1: base = ADDR_TIMER_CTL;
                    2: base = ADDR_DMA;
                    3: base = ADDR_LAST;
                    4: base = 16'hFFFE;
                    5: base = 16'hFF7F;
                    6: base = 16'hFDFF;
                    7: base = 16'hFE9F;
                    8: base = 16'hFEFF;
                    9: base = 16'h7FFF;
                    10: base = 16'h00FF;
                    11: base = 16'h0100;
                    default: base = 16'h9FFF;
                endcase
            end
            default: ;
        endcase
        off = 16'($urandom_range(32'(span)));
        if ($urandom_range(1) != 0)
            off = off & 16'h001F;
        return base + off;
    endfunction

    function automatic logic [15:0] echo_twin(input logic [15:0] a);
        if ($urandom_range(1) == 0)
            return a;
        if (a >= WRAM_BASE && a < 16'hDE00)
            return a + 16'h2000;
        if (a >= ADDR_ECHO && a < ADDR_SPRITE)
            return a - 16'h2000;
        return a;
    endfunction

    task automatic random_burst(input int count);
        int made;
        int kind;
        logic [15:0] a;
        logic [15:0] d;
        logic w;
        logic [7:0] k;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(99);
            a = pick_address();
            d = 16'($urandom);
            w = 1'($urandom);
            k = 8'($urandom);
            if (kind < 40)
            begin
                queue_cmd(CMD_WRITE, a, d, w, k);
                written_addrs.push_back(a);
                if (written_addrs.size() > 16)
                    void'(written_addrs.pop_front());
                made++;
                if ($urandom_range(9) < 7)
                begin
                    queue_cmd(CMD_READ, echo_twin(a), 16'($urandom), 1'($urandom), k);
                    made++;
                end
            end
            else if (kind < 70)
            begin
                if (written_addrs.size() != 0 && $urandom_range(1) != 0)
                    a = echo_twin(written_addrs[$urandom_range(written_addrs.size() - 1)]);
                queue_cmd(CMD_READ, a, d, w, k);
                made++;
            end
            else if (kind < 78)
            begin
                queue_cmd(CMD_KEYS, a, d, w, k);
                made++;
            end
            else if (kind < 88)
            begin
                queue_cmd(CMD_WRITE, ADDR_JOYPAD, d, 1'b0, k);
                queue_cmd(CMD_READ, ADDR_JOYPAD, 16'($urandom), 1'($urandom), k);
                made += 2;
            end
            else if (kind < 95)
            begin
                a = ($urandom_range(1) != 0) ? ADDR_TIMER_CTL : ADDR_DMA;
                if (w)
                    a = a - 16'd1;
                queue_cmd(CMD_WRITE, a, d, w, k);
                made++;
            end
            else
            begin
                queue_cmd(CMD_NOP, a, d, w, k);
                made++;
            end
        end
    endtask

    task automatic directed_items();
        queue_cmd(CMD_READ, ADDR_JOYPAD, 16'h0000, 1'b0, 8'h00);
        queue_cmd(CMD_READ, 16'h0000, 16'hFFFF, 1'b1, 8'hFF);
        queue_cmd(CMD_KEYS, 16'hFFFF, 16'h0000, 1'b0, 8'h5A);
        queue_cmd(CMD_WRITE, ADDR_JOYPAD, 16'h0020, 1'b0, 8'h00);
        queue_cmd(CMD_READ, ADDR_JOYPAD, 16'h0000, 1'b0, 8'h00);
        queue_cmd(CMD_WRITE, ADDR_JOYPAD, 16'hFF10, 1'b0, 8'h00);
        queue_cmd(CMD_READ, ADDR_JOYPAD, 16'h0000, 1'b0, 8'h00);
        queue_cmd(CMD_WRITE, ADDR_JOYPAD, 16'h00F0, 1'b0, 8'h00);
        queue_cmd(CMD_READ, ADDR_JOYPAD, 16'h0000, 1'b0, 8'h00);
        queue_cmd(CMD_WRITE, ADDR_DMA, 16'h007C, 1'b0, 8'h00);
        queue_cmd(CMD_WRITE, ADDR_TIMER_CTL, 16'h0005, 1'b0, 8'h00);
        queue_cmd(CMD_WRITE, ADDR_TIMER_CTL, 16'h00FD, 1'b0, 8'h00);
        queue_cmd(CMD_WRITE, 16'hFF06, 16'h0600, 1'b1, 8'h00);
        queue_cmd(CMD_WRITE, 16'hFF45, 16'hAB12, 1'b1, 8'h00);
        queue_cmd(CMD_WRITE, 16'hE123, 16'h0099, 1'b0, 8'h00);
        queue_cmd(CMD_READ, 16'hC123, 16'h0000, 1'b1, 8'h00);
        queue_cmd(CMD_WRITE, 16'hC200, 16'hBEEF, 1'b1, 8'h00);
        queue_cmd(CMD_READ, 16'hE200, 16'h0000, 1'b1, 8'h00);
        queue_cmd(CMD_WRITE, ADDR_UNUSABLE, 16'h0055, 1'b1, 8'h00);
        queue_cmd(CMD_READ, 16'hFEFF, 16'h0000, 1'b1, 8'h00);
        queue_cmd(CMD_WRITE, ADDR_LAST, 16'h3412, 1'b1, 8'h00);
        queue_cmd(CMD_READ, ADDR_LAST, 16'h0000, 1'b1, 8'h00);
        queue_cmd(CMD_WRITE, 16'h7FFF, 16'hC3A5, 1'b1, 8'h00);
        queue_cmd(CMD_READ, 16'h7FFF, 16'h0000, 1'b1, 8'h00);
        queue_cmd(CMD_NOP, ADDR_DMA, 16'hFFFF, 1'b1, 8'h00);
        queue_cmd(CMD_READ, 16'h00FF, 16'h0000, 1'b1, 8'h00);
    endtask

    initial
    begin
        clear_map();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_quiet();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_register(CFG_BOOT_OVERLAY, OVERLAY_PLAN[phase]);
            write_register(CFG_ROM_PROTECT, PROTECT_PLAN[phase]);
            if (phase == 2)
            begin
                send_idle_pct = 61;
                recv_idle_pct = 11;
            end
            else if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase == 0)
                directed_items();
            random_burst(65);
            if (phase == 1)
                wait_quiet();
            if (phase == 2)
                want_stall = 1'b1;
            random_burst(65);
        end
        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_rsps.size() == 0)
            $display("handheld_console_memory_bus_tb passed");
        else
            $display("handheld_console_memory_bus_tb failed");
        $finish;
    end

endmodule
